@@ design/dmtc_pkg.sv @@
package dmtc_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 8;

  localparam int unsigned CONFIRM_W = 4;
  localparam int unsigned RELEASE_W = 10;
  localparam int unsigned GAP_W     = 12;
  localparam int unsigned SHOWN_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CONFIRM_W-1:0] CONFIRM_RESET = CONFIRM_W'(2);
  localparam logic [RELEASE_W-1:0] RELEASE_RESET = RELEASE_W'(50);
  localparam logic [GAP_W-1:0]     GAP_RESET     = GAP_W'(300);

  localparam logic [SHOWN_W-1:0] SHOWN_MAX  = {SHOWN_W{1'b1}};
  localparam logic [SHOWN_W-1:0] DOUBLE_TAPS = SHOWN_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONFIRM = 2'd0,
    REG_RELEASE = 2'd1,
    REG_GAP     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAITING    = 2'd1,
    PH_CONFIRMING = 2'd2,
    PH_HELD       = 2'd3
  } phase_t;

endpackage

@@ design/debounced_multi_tap_counter_top.sv @@
// Channel | Handshake          | Payload
// in      | in_valid, in_stall | command, button_down
// out     | out_valid, out_stall | tap_count, double_tap
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// One tick beat is accepted every clock cycle while in_stall is low; the phase, timer,
// window and tap registers update at the accepting edge, which registers a report onto out or the skid.
// A two-entry output stage (result register plus skid) lets ticks keep flowing while
// a report waits; in_stall rises only when both entries hold reports.
// Synchronous reset returns to idle with the register defaults and clears both entries.
// The configuration port is always ready.
module debounced_multi_tap_counter_top #(
  parameter int unsigned COUNT_BITS = dmtc_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic                                button_down,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dmtc_pkg::SHOWN_W-1:0]        tap_count,
  output logic                                double_tap,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dmtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dmtc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned EXT_W = COUNT_BITS + dmtc_pkg::SHOWN_W;
  localparam logic [COUNT_BITS-1:0] TAPS_MAX = {COUNT_BITS{1'b1}};

  logic [dmtc_pkg::CONFIRM_W-1:0] confirm_ticks;
  logic [dmtc_pkg::RELEASE_W-1:0] release_limit_ticks;
  logic [dmtc_pkg::GAP_W-1:0]     gap_ticks;

  dmtc_pkg::phase_t                phase, phase_next;
  logic [dmtc_pkg::RELEASE_W-1:0]  phase_timer, phase_timer_next;
  logic [dmtc_pkg::GAP_W-1:0]      window_left, window_left_next;
  logic [COUNT_BITS-1:0]           taps_so_far, taps_so_far_next;

  logic                          report;
  logic [dmtc_pkg::SHOWN_W-1:0]  report_count;
  logic                          report_double;
  logic [EXT_W-1:0]              taps_ext;

  logic                          skid_valid;
  logic [dmtc_pkg::SHOWN_W-1:0]  skid_count;
  logic                          skid_double;

  logic in_accept;
  logic out_free;
  logic [dmtc_pkg::GAP_W-1:0] window_dec;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_ticks       <= dmtc_pkg::CONFIRM_RESET;
      release_limit_ticks <= dmtc_pkg::RELEASE_RESET;
      gap_ticks           <= dmtc_pkg::GAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (dmtc_pkg::cfg_reg_t'(cfg_index))
        dmtc_pkg::REG_CONFIRM: confirm_ticks <= cfg_data[dmtc_pkg::CONFIRM_W-1:0];
        dmtc_pkg::REG_RELEASE: release_limit_ticks <= cfg_data[dmtc_pkg::RELEASE_W-1:0];
        dmtc_pkg::REG_GAP:     gap_ticks <= cfg_data[dmtc_pkg::GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign window_dec = (window_left != '0) ? window_left - 1'b1 : window_left;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (command) begin
      phase_next = dmtc_pkg::PH_WAITING;
    end else begin
      case (phase)
        dmtc_pkg::PH_WAITING: begin
          if (window_left == '0) begin
            phase_next = dmtc_pkg::PH_IDLE;
          end else if (button_down) begin
            phase_next = dmtc_pkg::PH_CONFIRMING;
          end
        end
        dmtc_pkg::PH_CONFIRMING: begin
          if (phase_timer <= 1) begin
            phase_next = button_down ? dmtc_pkg::PH_HELD : dmtc_pkg::PH_WAITING;
          end
        end
        dmtc_pkg::PH_HELD: begin
          if (!button_down || phase_timer <= 1) begin
            phase_next = dmtc_pkg::PH_WAITING;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // Timers, tap count and report.
  always_comb begin
    phase_timer_next = phase_timer;
    window_left_next = window_left;
    taps_so_far_next = taps_so_far;
    report           = 1'b0;
    if (command) begin
      phase_timer_next = '0;
      window_left_next = gap_ticks;
      taps_so_far_next = '0;
    end else begin
      case (phase)
        dmtc_pkg::PH_WAITING: begin
          if (window_left == '0) begin
            report           = 1'b1;
            phase_timer_next = '0;
          end else begin
            window_left_next = window_left - 1'b1;
            if (button_down) begin
              phase_timer_next = dmtc_pkg::RELEASE_W'(confirm_ticks);
            end
          end
        end
        dmtc_pkg::PH_CONFIRMING: begin
          window_left_next = window_dec;
          if (phase_timer > 1) begin
            phase_timer_next = phase_timer - 1'b1;
          end else if (button_down) begin
            phase_timer_next = release_limit_ticks;
          end else begin
            phase_timer_next = '0;
          end
        end
        dmtc_pkg::PH_HELD: begin
          window_left_next = window_dec;
          if (!button_down) begin
            if (taps_so_far != TAPS_MAX) begin
              taps_so_far_next = taps_so_far + 1'b1;
            end
            window_left_next = gap_ticks;
            phase_timer_next = '0;
          end else if (phase_timer > 1) begin
            phase_timer_next = phase_timer - 1'b1;
          end else begin
            phase_timer_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign taps_ext      = EXT_W'(taps_so_far);
  assign report_count  = (taps_ext > EXT_W'(dmtc_pkg::SHOWN_MAX)) ? dmtc_pkg::SHOWN_MAX
                                                                   : taps_ext[dmtc_pkg::SHOWN_W-1:0];
  assign report_double = (taps_ext == EXT_W'(dmtc_pkg::DOUBLE_TAPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dmtc_pkg::PH_IDLE;
      phase_timer <= '0;
      window_left <= '0;
      taps_so_far <= '0;
    end else if (in_accept) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      window_left <= window_left_next;
      taps_so_far <= taps_so_far_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          tap_count  <= skid_count;
          double_tap <= skid_double;
          skid_valid <= 1'b0;
        end else if (in_accept && report) begin
          out_valid  <= 1'b1;
          tap_count  <= report_count;
          double_tap <= report_double;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (in_accept && report) begin
        skid_valid  <= 1'b1;
        skid_count  <= report_count;
        skid_double <= report_double;
      end
    end
  end

endmodule

@@ design/dmtc_checker.sv @@
module dmtc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                command,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [dmtc_pkg::SHOWN_W-1:0]        tap_count,
  input logic                                double_tap
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tap_count) && $stable(double_tap))
    else $error("stalled report changed");

  a_double_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (double_tap == (tap_count == dmtc_pkg::DOUBLE_TAPS)))
    else $error("double-tap flag disagrees with tap count");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("report or stall after reset");

  a_cmd_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command && !out_valid |=> !out_valid)
    else $error("session start produced a report");

endmodule

bind debounced_multi_tap_counter_top dmtc_checker u_dmtc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .command    (command),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .tap_count  (tap_count),
  .double_tap (double_tap)
);

@@ bench/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dmtc_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    logic command;
    logic down;
  } tick_t;

  typedef struct packed {
    logic [dmtc_pkg::SHOWN_W-1:0] count;
    logic                         dbl;
  } report_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            command = 1'b0;
  logic                            button_down = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [dmtc_pkg::SHOWN_W-1:0]    tap_count;
  logic                            double_tap;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [dmtc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dmtc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  debounced_multi_tap_counter_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .button_down (button_down),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tap_count   (tap_count),
    .double_tap  (double_tap),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block's registers and session state.
  logic [dmtc_pkg::CONFIRM_W-1:0] confirm_len = dmtc_pkg::CONFIRM_RESET;
  logic [dmtc_pkg::RELEASE_W-1:0] release_len = dmtc_pkg::RELEASE_RESET;
  logic [dmtc_pkg::GAP_W-1:0]     gap_len     = dmtc_pkg::GAP_RESET;
  dmtc_pkg::phase_t               press_phase = dmtc_pkg::PH_IDLE;
  logic [9:0]                     phase_count = '0;
  logic [dmtc_pkg::GAP_W-1:0]     window_left = '0;
  logic [dmtc_pkg::SHOWN_W-1:0]   taps_seen   = '0;

  tick_t   tick_queue[$];
  report_t expected_reports[$];
  int      queued_ticks = 0;
  int      error_count = 0;
  int      idle_pct = 35;
  int      rx_hold_trigger = 0;
  int      rx_hold_seen = 0;
  int      rx_hold_left = 0;

  function automatic void advance_tick(input logic cmd, input logic down);
    if (cmd) begin
      press_phase = dmtc_pkg::PH_WAITING;
      phase_count = '0;
      window_left = gap_len;
      taps_seen = '0;
      return;
    end
    case (press_phase)
      dmtc_pkg::PH_WAITING: begin
        if (window_left == '0) begin
          expected_reports.push_back('{count: taps_seen,
                                       dbl: taps_seen == dmtc_pkg::DOUBLE_TAPS});
          press_phase = dmtc_pkg::PH_IDLE;
          phase_count = '0;
        end else begin
          window_left = window_left - 1'b1;
          if (down) begin
            press_phase = dmtc_pkg::PH_CONFIRMING;
            phase_count = 10'(confirm_len);
          end
        end
      end
      dmtc_pkg::PH_CONFIRMING: begin
        if (window_left != '0) window_left = window_left - 1'b1;
        if (phase_count > 1) begin
          phase_count = phase_count - 1'b1;
        end else if (down) begin
          press_phase = dmtc_pkg::PH_HELD;
          phase_count = 10'(release_len);
        end else begin
          press_phase = dmtc_pkg::PH_WAITING;
          phase_count = '0;
        end
      end
      dmtc_pkg::PH_HELD: begin
        if (window_left != '0) window_left = window_left - 1'b1;
        if (!down) begin
          if (taps_seen != dmtc_pkg::SHOWN_MAX) taps_seen = taps_seen + 1'b1;
          window_left = gap_len;
          press_phase = dmtc_pkg::PH_WAITING;
          phase_count = '0;
        end else if (phase_count > 1) begin
          phase_count = phase_count - 1'b1;
        end else begin
          press_phase = dmtc_pkg::PH_WAITING;
          phase_count = '0;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= 10) $display("tb: %s", what);
  endtask

  // Tick beats go out whenever the queue has one, the random idle roll allows and no beat is held stalled.
  always @(posedge clk) begin : tick_driver
    tick_t next_tick;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_tick(command, button_down);
      if (!in_valid || !in_stall) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_tick = tick_queue.pop_front();
          in_valid <= 1'b1;
          command <= next_tick.command;
          button_down <= next_tick.down;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_trigger != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_trigger;
      rx_hold_left <= RX_HOLD_CYCLES;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  always @(posedge clk) begin : report_monitor
    report_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          flag_error($sformatf("unexpected report count=%0d double=%0b", tap_count, double_tap));
        end else begin
          want = expected_reports.pop_front();
          if (tap_count !== want.count || double_tap !== want.dbl)
            flag_error($sformatf("report mismatch: expected count=%0d double=%0b, got %0d %0b",
                                 want.count, want.dbl, tap_count, double_tap));
        end
      end
      out_stall <= (rx_hold_left != 0) || ($urandom_range(99) < idle_pct);
    end
  end

  task automatic push_tick(input logic cmd, input logic down);
    tick_queue.push_back('{command: cmd, down: down});
    queued_ticks++;
  endtask

  task automatic push_press(input int len);
    repeat (len) push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
  endtask

  // One session: a command, some presses of varied length, then enough quiet ticks to close.
  task automatic add_session(input int taps);
    int c = (confirm_len == 0) ? 1 : int'(confirm_len);
    int r = (release_len == 0) ? 1 : int'(release_len);
    int len;
    push_tick(1'b1, 1'($urandom_range(1)));
    repeat (taps) begin
      repeat ($urandom_range(2)) push_tick(1'b0, 1'b0);
      case ($urandom_range(9))
        0: len = $urandom_range(c, 1);
        1: len = c + r;
        2: len = c + r + 1;
        3: len = c + r + 1 + $urandom_range(4, 1);
        default: len = c + 1 + $urandom_range((r > 6) ? 5 : r - 1);
      endcase
      push_press(len);
    end
    repeat (int'(gap_len) + $urandom_range(3, 1)) push_tick(1'b0, 1'b0);
  endtask

  task automatic fill_random(input int n);
    int stop = queued_ticks + n;
    while (queued_ticks < stop) begin
      if ($urandom_range(9) < 2)
        repeat ($urandom_range(12, 4))
          push_tick(1'($urandom_range(9) == 0), 1'($urandom_range(1)));
      else
        add_session($urandom_range(4));
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dmtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dmtc_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      dmtc_pkg::REG_CONFIRM: confirm_len = data[dmtc_pkg::CONFIRM_W-1:0];
      dmtc_pkg::REG_RELEASE: release_len = data[dmtc_pkg::RELEASE_W-1:0];
      dmtc_pkg::REG_GAP:     gap_len = data[dmtc_pkg::GAP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [dmtc_pkg::CFG_DATA_W-1:0] c,
                          input logic [dmtc_pkg::CFG_DATA_W-1:0] r,
                          input logic [dmtc_pkg::CFG_DATA_W-1:0] g);
    wait_quiet();
    write_reg(dmtc_pkg::REG_CONFIRM, c);
    write_reg(dmtc_pkg::REG_RELEASE, r);
    write_reg(dmtc_pkg::REG_GAP, g);
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_session(2);

    set_regs(12'hFF2, 12'hC04, 12'h003);
    write_reg(REG_NONE, 12'hFFF);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    push_press(3);
    repeat (2) push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_press(3);
    repeat (3) push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    repeat (4) push_tick(1'b0, 1'b0);

    set_regs(12'd3, 12'd8, 12'd12);
    idle_pct = 0;
    fill_random(150);

    // Short gaps make reports pile up while the receiver holds off.
    set_regs(12'd1, 12'd2, 12'd1);
    idle_pct = 35;
    fill_random(150);
    rx_hold_trigger++;

    set_regs(12'd0, 12'd0, 12'd0);
    fill_random(60);

    set_regs(12'd1, 12'd1, 12'd1);
    push_tick(1'b1, 1'b0);
    repeat (260) push_press(2);
    repeat (3) push_tick(1'b0, 1'b0);

    set_regs(12'hFFF, 12'hFFF, 12'hFFF);
    push_tick(1'b1, 1'b0);
    push_press(60);
    push_press(16);
    push_press(20);
    repeat (5) push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b1);
    repeat (5) push_tick(1'b0, 1'b0);

    repeat (4) begin
      set_regs(12'($urandom_range(5, 1)), 12'($urandom_range(12, 1)),
               12'($urandom_range(15, 1)));
      if ($urandom_range(1)) write_reg(REG_NONE, 12'($urandom));
      fill_random(40);
    end

    wait_quiet();
    if (error_count == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
